// ----- sv/slab_bitmap_slot_allocator_macros.svh -----
// Assertion macros shared by the slab allocator modules.
`ifndef SLAB_BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define SLAB_BITMAP_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sbsa_pkg.sv -----
// Shared types, constants and functions of the slab bitmap slot allocator.
package sbsa_pkg;

  localparam int SIZE_CLASSES_DEF    = 12;
  localparam int SLABS_PER_CLASS_DEF = 4;
  localparam int SLOTS_PER_SLAB_DEF  = 64;
  localparam int DEFINED_SIZES       = 12;

  localparam int SIZE_W   = 16;
  localparam int CLASS_W  = 4;
  localparam int SLAB_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int BYTES_W  = 9;
  localparam int STATUS_W = 3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_SPACE    = 3'd1,
    ST_DOUBLE_FREE = 3'd2,
    ST_BAD_HANDLE  = 3'd3,
    ST_NOT_SMALL   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EVAL = 2'd1,
    S_DONE = 2'd2
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic next_slab;
    logic finish;
    logic push;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pre_reject;
    logic need_next;
    logic out_free;
  } sts_t;

  // Slot size in bytes of a size class.
  function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLASS_W-1:0] cls);
    logic [BYTES_W-1:0] b;
    case (cls)
      4'd0:    b = 9'd16;
      4'd1:    b = 9'd32;
      4'd2:    b = 9'd48;
      4'd3:    b = 9'd64;
      4'd4:    b = 9'd80;
      4'd5:    b = 9'd96;
      4'd6:    b = 9'd112;
      4'd7:    b = 9'd128;
      4'd8:    b = 9'd160;
      4'd9:    b = 9'd192;
      4'd10:   b = 9'd224;
      4'd11:   b = 9'd256;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  // Smallest class that fits a size of 1 to 256 bytes. Classes step by 16 up
  // to 128 bytes and by 32 above that.
  function automatic logic [CLASS_W-1:0] fit_class(input logic [SIZE_W-1:0] size);
    logic [BYTES_W-1:0] m1;
    logic [CLASS_W-1:0] c;
    m1 = size[BYTES_W-1:0] - 9'd1;
    if (m1[7]) begin
      c = 4'd8 + {2'b00, m1[6:5]};
    end else begin
      c = {1'b0, m1[6:4]};
    end
    return c;
  endfunction

endpackage

// ----- sv/slab_bitmap_slot_allocator.sv -----
// Rejected requests skip the bitmap; a free reads its slab once, and an allocate reads
// the slabs of its class in turn until one has a clear slot or the last slab is reached.
// Items are handled one at a time: a new one is accepted only after the previous result
// is loaded into the output register. Each scanned slab costs one registered read of the
// bitmap RAM. A new item is taken while the previous result still waits in the output register.
// Reset: all slabs read as empty at once through per-slab valid bits; no clearing pass.
module slab_bitmap_slot_allocator #(
  parameter int SIZE_CLASSES    = sbsa_pkg::SIZE_CLASSES_DEF,
  parameter int SLABS_PER_CLASS = sbsa_pkg::SLABS_PER_CLASS_DEF,
  parameter int SLOTS_PER_SLAB  = sbsa_pkg::SLOTS_PER_SLAB_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [sbsa_pkg::SIZE_W-1:0]    req_size_i,
  input  logic [sbsa_pkg::CLASS_W-1:0]   free_class_i,
  input  logic [sbsa_pkg::SLAB_W-1:0]    free_slab_i,
  input  logic [sbsa_pkg::SLOT_W-1:0]    free_slot_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sbsa_pkg::STATUS_W-1:0]  status_o,
  output logic [sbsa_pkg::CLASS_W-1:0]   got_class_o,
  output logic [sbsa_pkg::SLAB_W-1:0]    got_slab_o,
  output logic [sbsa_pkg::SLOT_W-1:0]    got_slot_o,
  output logic [sbsa_pkg::BYTES_W-1:0]   usable_bytes_o
);

  sbsa_pkg::ctl_t ctl;
  sbsa_pkg::sts_t sts;

  sbsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  sbsa_dp #(
    .SIZE_CLASSES    (SIZE_CLASSES),
    .SLABS_PER_CLASS (SLABS_PER_CLASS),
    .SLOTS_PER_SLAB  (SLOTS_PER_SLAB)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .cmd_i          (cmd_i),
    .req_size_i     (req_size_i),
    .free_class_i   (free_class_i),
    .free_slab_i    (free_slab_i),
    .free_slot_i    (free_slot_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .got_class_o    (got_class_o),
    .got_slab_o     (got_slab_o),
    .got_slot_o     (got_slot_o),
    .usable_bytes_o (usable_bytes_o)
  );

endmodule

// ----- sv/sbsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sbsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/sbsa_dp.sv -----
// Datapath: request registers, slab bitmap RAM, slot search and result registers.
`include "slab_bitmap_slot_allocator_macros.svh"

module sbsa_dp #(
  parameter int SIZE_CLASSES    = sbsa_pkg::SIZE_CLASSES_DEF,
  parameter int SLABS_PER_CLASS = sbsa_pkg::SLABS_PER_CLASS_DEF,
  parameter int SLOTS_PER_SLAB  = sbsa_pkg::SLOTS_PER_SLAB_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sbsa_pkg::ctl_t                 ctl_i,
  output sbsa_pkg::sts_t                 sts_o,
  input  logic                           cmd_i,
  input  logic [sbsa_pkg::SIZE_W-1:0]    req_size_i,
  input  logic [sbsa_pkg::CLASS_W-1:0]   free_class_i,
  input  logic [sbsa_pkg::SLAB_W-1:0]    free_slab_i,
  input  logic [sbsa_pkg::SLOT_W-1:0]    free_slot_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sbsa_pkg::STATUS_W-1:0]  status_o,
  output logic [sbsa_pkg::CLASS_W-1:0]   got_class_o,
  output logic [sbsa_pkg::SLAB_W-1:0]    got_slab_o,
  output logic [sbsa_pkg::SLOT_W-1:0]    got_slot_o,
  output logic [sbsa_pkg::BYTES_W-1:0]   usable_bytes_o
);

  localparam int LIVE    = (SIZE_CLASSES < sbsa_pkg::DEFINED_SIZES) ?
                           SIZE_CLASSES : sbsa_pkg::DEFINED_SIZES;
  localparam int DEPTH   = SIZE_CLASSES * SLABS_PER_CLASS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIDX_W  = $clog2(SLOTS_PER_SLAB);

  localparam logic [sbsa_pkg::SLAB_W-1:0] LAST_SLAB =
    sbsa_pkg::SLAB_W'(SLABS_PER_CLASS - 1);

  // Request registers.
  logic                          cmd_q;
  logic [sbsa_pkg::CLASS_W-1:0]  cls_q;
  logic [sbsa_pkg::SLAB_W-1:0]   slab_q;
  logic [sbsa_pkg::SLOT_W-1:0]   slot_q;
  logic [AW-1:0]                 addr_q;

  // Result and output registers.
  sbsa_pkg::status_e             res_status_q, res_status_d;
  logic [sbsa_pkg::CLASS_W-1:0]  res_class_q, res_class_d;
  logic [sbsa_pkg::SLAB_W-1:0]   res_slab_q, res_slab_d;
  logic [sbsa_pkg::SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [sbsa_pkg::BYTES_W-1:0]  res_bytes_q, res_bytes_d;

  logic                          out_valid_q;
  logic [sbsa_pkg::STATUS_W-1:0] out_status_q;
  logic [sbsa_pkg::CLASS_W-1:0]  out_class_q;
  logic [sbsa_pkg::SLAB_W-1:0]   out_slab_q;
  logic [sbsa_pkg::SLOT_W-1:0]   out_slot_q;
  logic [sbsa_pkg::BYTES_W-1:0]  out_bytes_q;

  // A slab whose valid bit is clear has never been written and reads as empty.
  logic [DEPTH-1:0]              vld_q;
  logic                          vld_rd_q;

  logic [sbsa_pkg::CLASS_W-1:0]  in_cls;
  logic                          alloc_bad, free_bad, pre_reject;
  logic [AW-1:0]                 in_addr, rd_addr;
  logic                          rd_en, wr_en;
  logic [SLOTS_PER_SLAB-1:0]     rdata, map_eff, wdata, alloc_mask, free_mask;
  logic                          full, bit_set;
  logic [SIDX_W-1:0]             lz_idx;

  assign in_cls    = sbsa_pkg::fit_class(req_size_i);
  assign alloc_bad = (req_size_i == '0) || (req_size_i > 16'd256) ||
                     ({1'b0, in_cls} >= 5'(LIVE));
  assign free_bad  = ({1'b0, free_class_i} >= 5'(LIVE)) ||
                     ({1'b0, free_slab_i} >= 3'(SLABS_PER_CLASS)) ||
                     ({1'b0, free_slot_i} >= 7'(SLOTS_PER_SLAB));
  assign pre_reject = (cmd_i == sbsa_pkg::CMD_FREE) ? free_bad : alloc_bad;

  always_comb begin
    if (cmd_i == sbsa_pkg::CMD_FREE) begin
      in_addr = AW'(free_class_i * SLABS_PER_CLASS + free_slab_i);
    end else begin
      in_addr = AW'(in_cls * SLABS_PER_CLASS);
    end
  end

  assign rd_en   = (ctl_i.take && !pre_reject) || ctl_i.next_slab;
  assign rd_addr = ctl_i.next_slab ? (addr_q + AW'(1)) : in_addr;

  sbsa_ram #(
    .WIDTH (SLOTS_PER_SLAB),
    .DEPTH (DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign map_eff = vld_rd_q ? rdata : '0;
  assign full    = &map_eff;
  assign bit_set = map_eff[slot_q[SIDX_W-1:0]];

  // Lowest clear slot of the slab that was read.
  always_comb begin
    lz_idx = '0;
    for (int i = SLOTS_PER_SLAB - 1; i >= 0; i--) begin
      if (!map_eff[i]) begin
        lz_idx = SIDX_W'(i);
      end
    end
  end

  always_comb begin
    alloc_mask = '0;
    alloc_mask[lz_idx] = 1'b1;
    free_mask = '0;
    free_mask[slot_q[SIDX_W-1:0]] = 1'b1;
  end

  assign wdata = (cmd_q == sbsa_pkg::CMD_FREE) ? (map_eff & ~free_mask)
                                               : (map_eff | alloc_mask);
  assign wr_en = ctl_i.finish &&
                 (((cmd_q == sbsa_pkg::CMD_FREE) && bit_set) ||
                  ((cmd_q == sbsa_pkg::CMD_ALLOC) && !full));

  assign sts_o.pre_reject = pre_reject;
  assign sts_o.need_next  = (cmd_q == sbsa_pkg::CMD_ALLOC) && full && (slab_q != LAST_SLAB);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    res_status_d = res_status_q;
    res_class_d  = res_class_q;
    res_slab_d   = res_slab_q;
    res_slot_d   = res_slot_q;
    res_bytes_d  = res_bytes_q;
    if (ctl_i.take) begin
      res_status_d = (cmd_i == sbsa_pkg::CMD_FREE) ? sbsa_pkg::ST_BAD_HANDLE
                                                   : sbsa_pkg::ST_NOT_SMALL;
      res_class_d  = '0;
      res_slab_d   = '0;
      res_slot_d   = '0;
      res_bytes_d  = '0;
    end else if (ctl_i.finish) begin
      res_class_d = '0;
      res_slab_d  = '0;
      res_slot_d  = '0;
      res_bytes_d = '0;
      if (cmd_q == sbsa_pkg::CMD_FREE) begin
        res_status_d = bit_set ? sbsa_pkg::ST_OK : sbsa_pkg::ST_DOUBLE_FREE;
      end else if (full) begin
        res_status_d = sbsa_pkg::ST_NO_SPACE;
      end else begin
        res_status_d = sbsa_pkg::ST_OK;
        res_class_d  = cls_q;
        res_slab_d   = slab_q;
        res_slot_d   = sbsa_pkg::SLOT_W'(lz_idx);
        res_bytes_d  = sbsa_pkg::class_bytes(cls_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      cmd_q  <= cmd_i;
      addr_q <= in_addr;
      if (cmd_i == sbsa_pkg::CMD_FREE) begin
        cls_q  <= free_class_i;
        slab_q <= free_slab_i;
      end else begin
        cls_q  <= in_cls;
        slab_q <= '0;
      end
      slot_q <= free_slot_i;
    end else if (ctl_i.next_slab) begin
      addr_q <= addr_q + AW'(1);
      slab_q <= slab_q + sbsa_pkg::SLAB_W'(1);
    end
    res_status_q <= res_status_d;
    res_class_q  <= res_class_d;
    res_slab_q   <= res_slab_d;
    res_slot_q   <= res_slot_d;
    res_bytes_q  <= res_bytes_d;
    if (ctl_i.push) begin
      out_status_q <= res_status_q;
      out_class_q  <= res_class_q;
      out_slab_q   <= res_slab_q;
      out_slot_q   <= res_slot_q;
      out_bytes_q  <= res_bytes_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[addr_q] <= 1'b1;
      end
      if (rd_en) begin
        vld_rd_q <= vld_q[rd_addr];
      end
      if (ctl_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign got_class_o    = out_class_q;
  assign got_slab_o     = out_slab_q;
  assign got_slot_o     = out_slot_q;
  assign usable_bytes_o = out_bytes_q;

  `SBSA_ASSERT_SAME(a_no_rw_collide, wr_en && rd_en, addr_q != rd_addr,
                    "bitmap read and write hit the same slab in one cycle")
  `SBSA_ASSERT_NEXT(a_alloc_sets_valid, wr_en, vld_q[$past(addr_q)],
                    "written slab is not marked valid")

endmodule

// ----- sv/sbsa_ctrl.sv -----
// Controller: sequences acceptance, slab scan, result capture and output load.
`include "slab_bitmap_slot_allocator_macros.svh"

module sbsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sbsa_pkg::sts_t  sts_i,
  output sbsa_pkg::ctl_t  ctl_o
);

  sbsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    unique case (state_q)
      sbsa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.take = 1'b1;
          // Rejected requests skip the bitmap entirely.
          state_d = sts_i.pre_reject ? sbsa_pkg::S_DONE : sbsa_pkg::S_EVAL;
        end
      end
      sbsa_pkg::S_EVAL: begin
        if (sts_i.need_next) begin
          ctl_o.next_slab = 1'b1;
        end else begin
          ctl_o.finish = 1'b1;
          state_d      = sbsa_pkg::S_DONE;
        end
      end
      sbsa_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.push = 1'b1;
          state_d    = sbsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sbsa_pkg::S_IDLE;
      end
    endcase
  end

  `SBSA_ASSERT_SAME(a_push_needs_room, ctl_o.push, sts_i.out_free,
                    "result loaded while the output register is still occupied")
  `SBSA_ASSERT_NEXT(a_reject_skips_scan, ctl_o.take && sts_i.pre_reject,
                    state_q == sbsa_pkg::S_DONE,
                    "rejected request entered the slab scan")

endmodule
